>>> rtl/core/ready_frame_stream_scanner_macros.svh
// Assertion macros used by the frame scanner module rfss_scan.
// Expects signals named clk and arst_n in the module that uses them.
`ifndef READY_FRAME_STREAM_SCANNER_MACROS_SVH
`define READY_FRAME_STREAM_SCANNER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define RFSS_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define RFSS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/core/rfss_pkg.sv
// Types and constants of the length-prefixed frame scanner.
// No dependencies; used by every module of the block.
package rfss_pkg;

	// Header is one tag byte and four length bytes
	localparam logic [2:0]  HDR_BYTES    = 3'd5;
	localparam logic [2:0]  HDR_LEN_LAST = 3'd4;
	localparam logic [31:0] LEN_MIN      = 32'd4;
	localparam logic [7:0]  EMPTY_STATUS = 8'h49;
	localparam logic [7:0]  READY_TAG_RST = 8'h5A;

	typedef enum logic [1:0] {
		ERR_OK     = 2'd0,
		ERR_SHORT  = 2'd1,
		ERR_TRUNC  = 2'd2,
		ERR_HALTED = 2'd3
	} err_code_t;

	typedef struct packed {
		logic [7:0] byte_value;
		logic       last_byte;
	} in_item_t;

	typedef struct packed {
		logic [1:0] error_code;
		logic       frame_done;
		logic [7:0] frame_tag;
		logic       ready_done;
		logic [7:0] txn_status;
	} out_item_t;

	// Handshake between the input register and the result register
	typedef struct packed {
		logic valid; // input register holds an item
		logic hold;  // result register is full and stalled
	} stage_ctl_t;

endpackage

>>> rtl/core/rfss_in_stage.sv
// Scanner input register: one byte item per cycle unless stalled.
// Depends on rfss_pkg.
module rfss_in_stage (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                byte_valid,
	output logic                byte_stall,
	input  rfss_pkg::in_item_t  byte_item,
	input  logic                hold,
	output logic                valid_s1,
	output rfss_pkg::in_item_t  item_s1
);

	logic take;

	// Stall only when the held item cannot move on
	assign byte_stall = valid_s1 & hold;
	assign take       = byte_valid & ~byte_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (!hold) begin
			valid_s1 <= 1'b0;
		end
	end

	// Payload, no reset
	always_ff @(posedge clk) begin
		if (take) begin
			item_s1 <= byte_item;
		end
	end

endmodule

>>> rtl/core/rfss_scan.sv
// Frame position tracker: header/payload state and per-item result logic.
// Depends on rfss_pkg and the assertion macro header.
`include "ready_frame_stream_scanner_macros.svh"

module rfss_scan (
	input  logic                 clk,
	input  logic                 arst_n,
	input  rfss_pkg::stage_ctl_t ctl,
	input  rfss_pkg::in_item_t   item_s1,
	input  logic [7:0]           ready_tag,
	output rfss_pkg::out_item_t  res
);

	logic        advance;
	logic [2:0]  hdr_cnt_q, hdr_cnt_n;
	logic [7:0]  cur_tag_q, cur_tag_n;
	logic [31:0] len_q, len_n;
	logic [31:0] left_q, left_n;
	logic [7:0]  status_q, status_n;
	logic        captured_q, captured_n;
	logic        halted_q, halted_n;
	logic        is_ready;
	logic        clear;

	assign advance  = ctl.valid & ~ctl.hold;
	assign is_ready = (cur_tag_q == ready_tag);

	// Next state and result for the item in the input register
	always_comb begin
		hdr_cnt_n  = hdr_cnt_q;
		cur_tag_n  = cur_tag_q;
		len_n      = len_q;
		left_n     = left_q;
		status_n   = status_q;
		captured_n = captured_q;
		halted_n   = halted_q;
		clear      = 1'b0;
		res        = '0;

		if (halted_q) begin
			res.error_code = rfss_pkg::ERR_HALTED;
		end else begin
			unique case (hdr_cnt_q)
				3'd0: begin
					cur_tag_n  = item_s1.byte_value;
					len_n      = '0;
					captured_n = 1'b0;
					status_n   = '0;
					hdr_cnt_n  = 3'd1;
				end
				3'd1, 3'd2, 3'd3, 3'd4: begin
					len_n     = {len_q[23:0], item_s1.byte_value};
					hdr_cnt_n = hdr_cnt_q + 3'd1;
					if (hdr_cnt_q == rfss_pkg::HDR_LEN_LAST) begin
						// length below four halts the scanner
						if (len_n[31:2] == 30'd0) begin
							halted_n       = 1'b1;
							res.error_code = rfss_pkg::ERR_SHORT;
						end else begin
							left_n = len_n - rfss_pkg::LEN_MIN;
							if (len_n == rfss_pkg::LEN_MIN) begin
								// empty payload: frame ends on the header
								res.frame_done = 1'b1;
								res.frame_tag  = cur_tag_q;
								if (is_ready) begin
									res.ready_done = 1'b1;
									res.txn_status = rfss_pkg::EMPTY_STATUS;
								end
								clear = 1'b1;
							end
						end
					end
				end
				default: begin
					// payload byte
					if (is_ready && !captured_q) begin
						status_n   = item_s1.byte_value;
						captured_n = 1'b1;
					end
					if (left_q != 32'd0) begin
						left_n = left_q - 32'd1;
					end
					if (left_q <= 32'd1) begin
						res.frame_done = 1'b1;
						res.frame_tag  = cur_tag_q;
						if (is_ready) begin
							res.ready_done = 1'b1;
							res.txn_status = captured_n ? status_n : rfss_pkg::EMPTY_STATUS;
						end
						clear = 1'b1;
					end
				end
			endcase

			if (clear) begin
				hdr_cnt_n = '0;
			end

			// request ends inside an open frame
			if (item_s1.last_byte && !halted_n && res.error_code == rfss_pkg::ERR_OK
				&& hdr_cnt_n != 3'd0) begin
				res       = '0;
				res.error_code = rfss_pkg::ERR_TRUNC;
				clear     = 1'b1;
				hdr_cnt_n = '0;
			end

			if (clear) begin
				cur_tag_n  = '0;
				len_n      = '0;
				left_n     = '0;
				status_n   = '0;
				captured_n = 1'b0;
			end
		end
	end

	// State registers, updated as the item moves to the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hdr_cnt_q  <= '0;
			cur_tag_q  <= '0;
			len_q      <= '0;
			left_q     <= '0;
			status_q   <= '0;
			captured_q <= 1'b0;
			halted_q   <= 1'b0;
		end else if (advance) begin
			hdr_cnt_q  <= hdr_cnt_n;
			cur_tag_q  <= cur_tag_n;
			len_q      <= len_n;
			left_q     <= left_n;
			status_q   <= status_n;
			captured_q <= captured_n;
			halted_q   <= halted_n;
		end
	end

	`RFSS_ASSERT_NEXT(a_halt_sticky, halted_q, halted_q, "halted cleared without reset")
	`RFSS_ASSERT_NEXT(a_short_halts, advance && res.error_code == rfss_pkg::ERR_SHORT,
		halted_q, "short length did not halt")
	`RFSS_ASSERT_NOW(a_hdr_range, 1'b1, hdr_cnt_q <= rfss_pkg::HDR_BYTES,
		"header count out of range")
	`RFSS_ASSERT_NOW(a_ready_in_frame, res.ready_done,
		res.frame_done && res.error_code == rfss_pkg::ERR_OK, "ready without frame end")

endmodule

>>> rtl/core/rfss_out_stage.sv
// Result register of the frame scanner with its valid flag.
// Depends on rfss_pkg.
module rfss_out_stage (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                valid_s1,
	input  rfss_pkg::out_item_t res,
	output logic                hold,
	output logic                result_valid,
	input  logic                result_stall,
	output rfss_pkg::out_item_t result_item
);

	logic load;

	// Full and stalled: upstream must wait
	assign hold = result_valid & result_stall;
	assign load = valid_s1 & ~hold;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (load) begin
			result_valid <= 1'b1;
		end else if (!result_stall) begin
			result_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			result_item <= res;
		end
	end

endmodule

>>> rtl/core/ready_frame_stream_scanner.sv
// Top level of the length-prefixed frame scanner.
// Depends on rfss_pkg, rfss_in_stage, rfss_scan and rfss_out_stage.
//
// Usage:
//   byte channel (byte_valid/byte_stall/byte_item): one stream byte per item,
//   with last_byte marking the end of a request. result channel
//   (result_valid/result_stall/result_item): exactly one result per byte,
//   in order. cfg channel (cfg_valid/cfg_ready/cfg_data) writes ready_tag;
//   cfg_ready is always high, write only while no item is in flight.
// Path: an accepted byte passes the input register, then the result register.
// Throughput: one byte per cycle unless byte_stall is high; the frame state
//   update is a single pass of logic between the input register and the result register.
// Stall: while result_stall holds a full result register, one more byte is
//   taken into the input register if it is empty, then byte_stall rises
//   until the result is taken.
// Reset: arst_n clears both registers' valid flags, the frame state and
//   the halt flag, and sets ready_tag to 0x5A.
module ready_frame_stream_scanner (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                byte_valid,
	output logic                byte_stall,
	input  rfss_pkg::in_item_t  byte_item,
	output logic                result_valid,
	input  logic                result_stall,
	output rfss_pkg::out_item_t result_item,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [7:0]          cfg_data
);

	logic                 valid_s1;
	rfss_pkg::in_item_t   item_s1;
	rfss_pkg::out_item_t  res;
	rfss_pkg::stage_ctl_t ctl;
	logic                 hold;
	logic [7:0]           ready_tag_q;

	// Configuration register
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ready_tag_q <= rfss_pkg::READY_TAG_RST;
		end else if (cfg_valid && cfg_ready) begin
			ready_tag_q <= cfg_data;
		end
	end

	assign ctl.valid = valid_s1;
	assign ctl.hold  = hold;

	rfss_in_stage u_in (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (byte_valid),
		.byte_stall (byte_stall),
		.byte_item  (byte_item),
		.hold       (hold),
		.valid_s1   (valid_s1),
		.item_s1    (item_s1)
	);

	rfss_scan u_scan (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.item_s1   (item_s1),
		.ready_tag (ready_tag_q),
		.res       (res)
	);

	rfss_out_stage u_out (
		.clk          (clk),
		.arst_n       (arst_n),
		.valid_s1     (valid_s1),
		.res          (res),
		.hold         (hold),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result_item  (result_item)
	);

endmodule
